// ----- hw/rtl/auto_repeat_time_setter_macros.svh -----
// Assertion macros for the up/down time setter.
`ifndef AUTO_REPEAT_TIME_SETTER_MACROS_SVH
`define AUTO_REPEAT_TIME_SETTER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define ARTS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("time setter check failed");

// Next-cycle implication, checked outside reset
`define ARTS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("time setter check failed");

`else

`define ARTS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ARTS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/arts_pkg.sv -----
// Shared types, constants and the step-size table of the time setter.
`default_nettype none

package arts_pkg;

    // Field widths
    localparam int TIME_W = 15;
    localparam int MODE_W = 3;
    localparam int HOLD_W = 4;
    localparam int STEP_W = 12;

    // Parameter defaults
    localparam int unsigned MAX_SECONDS_DEF  = 18000;
    localparam int unsigned REPEAT_POLLS_DEF = 10;

    // Step mode codes
    localparam logic [MODE_W-1:0] MODE_1S    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_10S   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_60S   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_600S  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_3600S = 3'd4;

    // Step sizes in seconds
    localparam logic [STEP_W-1:0] STEP_1S    = 12'd1;
    localparam logic [STEP_W-1:0] STEP_10S   = 12'd10;
    localparam logic [STEP_W-1:0] STEP_60S   = 12'd60;
    localparam logic [STEP_W-1:0] STEP_600S  = 12'd600;
    localparam logic [STEP_W-1:0] STEP_3600S = 12'd3600;

    // Which buttons fire a step on this request
    typedef struct packed {
        logic up;
        logic down;
    } arts_fire_t;

    // One result item
    typedef struct packed {
        logic [TIME_W-1:0] time_seconds;
        logic              changed;
    } arts_result_t;

    // Map a mode code to its step; unused codes give one second
    function automatic logic [STEP_W-1:0] step_size(input logic [MODE_W-1:0] mode);
        logic [STEP_W-1:0] step;
        case (mode)
            MODE_1S:    step = STEP_1S;
            MODE_10S:   step = STEP_10S;
            MODE_60S:   step = STEP_60S;
            MODE_600S:  step = STEP_600S;
            MODE_3600S: step = STEP_3600S;
            default:    step = STEP_1S;
        endcase
        return step;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/arts_if.sv -----
// Valid/ready channel interfaces for button polls and time results.
`default_nettype none

interface arts_poll_if;
    logic valid;
    logic ready;
    logic up_pressed;
    logic down_pressed;

    modport source (output valid, output up_pressed, output down_pressed, input ready);
    modport sink   (input valid, input up_pressed, input down_pressed, output ready);
endinterface

interface arts_result_if;
    logic                          valid;
    logic                          ready;
    logic [arts_pkg::TIME_W-1:0]   time_seconds;
    logic                          changed;

    modport source (output valid, output time_seconds, output changed, input ready);
    modport sink   (input valid, input time_seconds, input changed, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/arts_button.sv -----
// Press detector and auto-repeat hold counter for one button.
`default_nettype none

module arts_button #(
    parameter int unsigned REPEAT_POLLS = arts_pkg::REPEAT_POLLS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  logic pressed,
    output logic fire
);
    import arts_pkg::*;

    localparam logic [HOLD_W-1:0] REPEAT_CNT = HOLD_W'(REPEAT_POLLS);

    logic              released_reg;
    logic              released_next;
    logic [HOLD_W-1:0] hold_reg;
    logic [HOLD_W-1:0] hold_next;
    logic [HOLD_W-1:0] hold_inc;

    // Fire on a fresh press or when the hold count reaches the repeat period
    always_comb
    begin
        hold_inc      = hold_reg + HOLD_W'(1);
        fire          = pressed && (released_reg || (hold_inc >= REPEAT_CNT));
        released_next = !pressed;
        hold_next     = hold_reg;
        if (pressed)
        begin
            hold_next = fire ? '0 : hold_inc;
        end
    end

    // Advance the button state on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            released_reg <= 1'b1;
            hold_reg     <= '0;
        end
        else if (accept)
        begin
            released_reg <= released_next;
            hold_reg     <= hold_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/arts_time_step.sv -----
// Stored time value with saturating up then down steps.
`default_nettype none

module arts_time_step #(
    parameter int unsigned MAX_SECONDS = arts_pkg::MAX_SECONDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [arts_pkg::MODE_W-1:0]   step_mode,
    input  arts_pkg::arts_fire_t          fire,
    output logic [arts_pkg::TIME_W-1:0]   cur_time,
    output logic [arts_pkg::TIME_W-1:0]   next_time,
    output logic                          changed
);
    import arts_pkg::*;

    localparam logic [TIME_W:0] MAX_EXT = (TIME_W + 1)'(MAX_SECONDS);

    logic [TIME_W-1:0] time_reg;
    logic [STEP_W-1:0] step;
    logic [TIME_W-1:0] step_t;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] after_up;

    // Apply up with a clamp at the top, then down with a clamp at zero
    always_comb
    begin
        step     = step_size(step_mode);
        step_t   = TIME_W'(step);
        sum      = {1'b0, time_reg} + (TIME_W + 1)'(step);
        after_up = time_reg;
        if (fire.up)
        begin
            after_up = (sum > MAX_EXT) ? MAX_EXT[TIME_W-1:0] : sum[TIME_W-1:0];
        end
        next_time = after_up;
        if (fire.down)
        begin
            next_time = (after_up >= step_t) ? (after_up - step_t) : '0;
        end
        changed = fire.up || fire.down;
    end

    assign cur_time = time_reg;

    // Hold the time value between requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
        end
        else if (accept)
        begin
            time_reg <= next_time;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/auto_repeat_time_setter.sv -----
// Top level of the up/down button time setter with auto-repeat.
//
// Usage: each request on poll carries the up and down button levels of one
// poll. Each accepted request yields exactly one result on the result channel:
// the time in seconds after that poll and a flag that is high when a button
// applied a step. A fresh press steps at once; a held button steps again on
// every REPEAT_POLLS-th held poll. Step size comes from the 3-bit mode
// register written through cfg_we / cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Throughput: one request per cycle while poll.ready is high; the time value
// and button counters are updated in a single pass between the state
// registers and the output stage. Stall: an output register plus a one-entry
// skid register absorb a stalled receiver; poll.ready drops only while the
// skid register is full and rises again once the receiver takes a result.
// Reset: time value 0, both buttons released, hold counters 0, mode 1 s,
// output and skid stages empty.
`default_nettype none
`include "auto_repeat_time_setter_macros.svh"

module auto_repeat_time_setter #(
    parameter int unsigned MAX_SECONDS  = arts_pkg::MAX_SECONDS_DEF,
    parameter int unsigned REPEAT_POLLS = arts_pkg::REPEAT_POLLS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [arts_pkg::MODE_W-1:0]   cfg_wdata,
    arts_poll_if.sink                     poll,
    arts_result_if.source                 result
);
    import arts_pkg::*;

    logic [MODE_W-1:0] step_mode_reg;
    logic              accept;
    arts_fire_t        fire;
    logic [TIME_W-1:0] cur_time;
    logic [TIME_W-1:0] next_time;
    logic              changed;
    arts_result_t      new_res;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    arts_result_t      out_data_reg;
    arts_result_t      skid_data_reg;
    logic              out_stall;

    // Hold the step mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_mode_reg <= MODE_1S;
        end
        else if (cfg_we)
        begin
            step_mode_reg <= cfg_wdata;
        end
    end

    assign poll.ready = !skid_valid_reg;
    assign accept     = poll.valid && poll.ready;

    arts_button #(
        .REPEAT_POLLS (REPEAT_POLLS)
    ) u_up_button (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .pressed (poll.up_pressed),
        .fire    (fire.up)
    );

    arts_button #(
        .REPEAT_POLLS (REPEAT_POLLS)
    ) u_down_button (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .pressed (poll.down_pressed),
        .fire    (fire.down)
    );

    arts_time_step #(
        .MAX_SECONDS (MAX_SECONDS)
    ) u_time_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .step_mode (step_mode_reg),
        .fire      (fire),
        .cur_time  (cur_time),
        .next_time (next_time),
        .changed   (changed)
    );

    assign new_res = '{time_seconds: next_time, changed: changed};

    // Output stage control: park a new result in the skid when output stalls
    always_comb
    begin
        out_stall       = out_valid_reg && !result.ready;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_stall)
        begin
            if (accept)
            begin
                skid_valid_next = 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = accept;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Move result payloads through the output and skid registers
    always_ff @(posedge clk)
    begin
        if (out_stall)
        begin
            if (accept)
            begin
                skid_data_reg <= new_res;
            end
        end
        else if (skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (accept)
        begin
            out_data_reg <= new_res;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.time_seconds = out_data_reg.time_seconds;
    assign result.changed      = out_data_reg.changed;

    // Checks
    `ARTS_ASSERT_IMP(a_skid_needs_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `ARTS_ASSERT_IMP(a_time_in_range, clk, rst_n, out_valid_reg, (out_data_reg.time_seconds <= TIME_W'(MAX_SECONDS)))
    `ARTS_ASSERT_IMP(a_idle_keeps_time, clk, rst_n, (accept && !changed), (next_time == cur_time))
    `ARTS_ASSERT_NXT(a_skid_on_stall, clk, rst_n, (!out_stall && !skid_valid_reg), !skid_valid_reg)

endmodule

`default_nettype wire
